// ===== src/logistic_map_oscillator_assert.svh =====
// assertion macros used by the checker file
`ifndef LOGISTIC_MAP_OSCILLATOR_ASSERT_SVH
`define LOGISTIC_MAP_OSCILLATOR_ASSERT_SVH

// same-cycle implication, off while reset is held
`define LMO_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lmo assertion failed");

// next-cycle implication, off while reset is held
`define LMO_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lmo assertion failed");

`endif

// ===== src/lmo_pkg.sv =====
`default_nettype none

package lmo_pkg;

    localparam int STATE_FRAC_BITS_DEF = 24;
    localparam int SAMPLE_BITS_DEF     = 16;

    localparam int KNOB_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int CNT_BITS      = 6;

    localparam logic [CFG_IDX_BITS-1:0] REG_RATE_KNOB   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_KNOB = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOD_DEPTH   = 2'd2;

    // constants held in Q48
    localparam logic [63:0] Q48_CMIN   = 64'd1002050917089935;
    localparam logic [63:0] Q48_CRANGE = 64'd95701492081623;
    localparam logic [63:0] Q48_OFFR   = 64'd28147216196089;
    localparam logic [63:0] Q48_MODK   = 64'd7036874417766;

    typedef logic [1:0] mul_kind_t;

    // knob product: 16-bit multiplier, shift 16
    localparam mul_kind_t MUL_KNOB = 2'd0;
    // modulation product: magnitude multiplier, shift S-2
    localparam mul_kind_t MUL_MAG  = 2'd1;
    // map product: F-bit multiplier, shift F
    localparam mul_kind_t MUL_MAP  = 2'd2;

    typedef struct packed {
        logic      start;
        mul_kind_t kind;
    } mul_req_t;

    function automatic int lmo_width(input int f, input int s);
        int w;
        w = f + 2;
        if (s > w)
            w = s;
        if (KNOB_BITS > w)
            w = KNOB_BITS;
        return w;
    endfunction

    // round half up from Q48 to Qf
    function automatic logic [63:0] q48_to_qf(input logic [63:0] v, input int f);
        logic [63:0] r;
        if (f >= 48)
            r = v;
        else
            r = (v + (64'd1 << (47 - f))) >> (48 - f);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/lmo_if.sv =====
`default_nettype none

interface lmo_in_if import lmo_pkg::*; #(
    parameter int S = SAMPLE_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic signed [S-1:0] mod_sample;

    modport source (output valid, output mod_sample, input ready);
    modport sink   (input valid, input mod_sample, output ready);
endinterface

interface lmo_out_if import lmo_pkg::*; #(
    parameter int S = SAMPLE_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic signed [S-1:0] x_level;
    logic signed [S-1:0] y_level;

    modport source (output valid, output x_level, output y_level, input ready);
    modport sink   (input valid, input x_level, input y_level, output ready);
endinterface

`default_nettype wire

// ===== src/lmo_serial_mul.sv =====
`default_nettype none

module lmo_serial_mul import lmo_pkg::*; #(
    parameter int F = STATE_FRAC_BITS_DEF,
    parameter int S = SAMPLE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mul_req_t                    req,
    input  wire logic [lmo_width(F, S)-1:0]  a,
    input  wire logic [lmo_width(F, S)-1:0]  b,
    output logic                             done,
    output logic [lmo_width(F, S)-1:0]       result
);

    localparam int W = lmo_width(F, S);
    localparam int P = 2 * W;

    logic [P-1:0]        acc_reg, acc_next;
    logic [W-1:0]        a_reg, a_next;
    logic [W-1:0]        b_reg, b_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    mul_kind_t           kind_reg, kind_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [W-1:0]        b_aligned;
    logic [CNT_BITS-1:0] n_bits;

    // multiplier bits left-aligned so they leave msb first
    always_comb
    begin
        unique case (req.kind)
            MUL_KNOB:
            begin
                b_aligned = b << (W - KNOB_BITS);
                n_bits    = CNT_BITS'(KNOB_BITS);
            end
            MUL_MAG:
            begin
                b_aligned = b << (W - (S - 1));
                n_bits    = CNT_BITS'(S - 1);
            end
            MUL_MAP:
            begin
                b_aligned = b << (W - F);
                n_bits    = CNT_BITS'(F);
            end
            default:
            begin
                b_aligned = b;
                n_bits    = CNT_BITS'(W);
            end
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        kind_next = kind_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            a_next    = a;
            b_next    = b_aligned;
            cnt_next  = n_bits;
            kind_next = req.kind;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg << 1) + (b_reg[W-1] ? {{W{1'b0}}, a_reg} : {P{1'b0}});
            b_next   = b_reg << 1;
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            kind_reg <= MUL_KNOB;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    always_comb
    begin
        unique case (kind_reg)
            MUL_KNOB: result = acc_reg[KNOB_BITS +: W];
            MUL_MAG:  result = acc_reg[(S - 2) +: W];
            MUL_MAP:  result = acc_reg[F +: W];
            default:  result = acc_reg[W-1:0];
        endcase
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== src/logistic_map_oscillator.sv =====
// Pair of chaotic logistic-map oscillators. Every modulation sample taken on
// mod_ch advances x' = C*x*(1-x) and y' = (C+offset)*y*(1-y) once and gives
// one beat on map_ch carrying 2x'-1 and 2y'-1 in Q1.(SAMPLE_BITS-1). C is
// 3.56 + 0.34*rate_knob plus the clamped, depth-scaled modulation, held to
// 3.56..3.9; the offset is 0.099999*offset_knob. State is unsigned
// Q0.STATE_FRAC_BITS and starts at 0.1 after reset. All eight products of a
// sample go in turn through one bit-serial shift-and-add multiplier, and mod_ch
// is ready only between samples; a finished result waits in the output
// register while the next sample is taken. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no sample
// is in flight, as the block itself does not enforce it.
`default_nettype none

module logistic_map_oscillator import lmo_pkg::*; #(
    parameter int STATE_FRAC_BITS = STATE_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    lmo_in_if.sink                        mod_ch,
    lmo_out_if.source                     map_ch
);

    localparam int F = STATE_FRAC_BITS;
    localparam int S = SAMPLE_BITS;
    localparam int W = lmo_width(F, S);

    localparam logic [W-1:0]   ONE      = W'(1) << F;
    localparam logic [F-1:0]   CRANGE_Q = F'(q48_to_qf(Q48_CRANGE, F));
    localparam logic [F+1:0]   CMIN_Q   = (F + 2)'(q48_to_qf(Q48_CMIN, F));
    localparam logic [F+1:0]   CMAX_Q   = CMIN_Q + {2'b00, CRANGE_Q};
    localparam logic [F-1:0]   MODK_Q   = F'(q48_to_qf(Q48_MODK, F));
    localparam logic [F-1:0]   OFFR_Q   = F'(q48_to_qf(Q48_OFFR, F));
    localparam logic [F-1:0]   INIT_Q   = F'(((64'd1 << F) + 64'd5) / 64'd10);
    localparam logic [S-1:0]   UNIT     = S'(1) << (S - 2);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    localparam logic [2:0] OP_DEPTH  = 3'd0;
    localparam logic [2:0] OP_MOD    = 3'd1;
    localparam logic [2:0] OP_RATE   = 3'd2;
    localparam logic [2:0] OP_OFFSET = 3'd3;
    localparam logic [2:0] OP_XPOLY  = 3'd4;
    localparam logic [2:0] OP_XSTEP  = 3'd5;
    localparam logic [2:0] OP_YPOLY  = 3'd6;
    localparam logic [2:0] OP_YSTEP  = 3'd7;

    logic [1:0]           state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [KNOB_BITS-1:0] rate_reg, rate_next;
    logic [KNOB_BITS-1:0] offs_reg, offs_next;
    logic [KNOB_BITS-1:0] depth_reg, depth_next;
    logic [F-1:0]         x_reg, x_next;
    logic [F-1:0]         y_reg, y_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 neg_reg, neg_next;
    logic [S-2:0]         mag_reg, mag_next;
    logic [F-1:0]         m_reg, m_next;
    logic [F-1:0]         r_reg, r_next;
    logic [F-1:0]         off_reg, off_next;
    logic [F+1:0]         c_reg, c_next;
    logic [F-1:0]         p_reg, p_next;
    logic [S-1:0]         x_level_reg, x_level_next;
    logic [S-1:0]         y_level_reg, y_level_next;

    logic [S-1:0]         in_raw;
    logic                 in_neg;
    logic [S-1:0]         in_abs;
    logic [S-2:0]         in_mag;
    logic [F:0]           c_sum;
    logic [F+1:0]         c_calc;
    logic [S-1:0]         x_trunc, y_trunc;

    mul_req_t             mul_req;
    logic [W-1:0]         mul_a, mul_b, mul_result;
    logic                 mul_done;
    logic [F-1:0]         res_f;

    lmo_serial_mul #(
        .F (F),
        .S (S)
    ) u_lmo_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_result)
    );

    assign res_f = mul_result[F-1:0];

    // modulation magnitude, clamped to one unit
    assign in_raw = mod_ch.mod_sample;
    assign in_neg = in_raw[S-1];
    assign in_abs = in_neg ? (~in_raw + S'(1)) : in_raw;
    assign in_mag = (in_abs > UNIT) ? UNIT[S-2:0] : in_abs[S-2:0];

    // map parameter from rate term and signed modulation term
    always_comb
    begin
        if (neg_reg)
            c_sum = (m_reg >= r_reg) ? '0 : ({1'b0, r_reg} - {1'b0, m_reg});
        else
            c_sum = {1'b0, r_reg} + {1'b0, m_reg};
        c_calc = (c_sum > {1'b0, CRANGE_Q}) ? CMAX_Q : (CMIN_Q + {1'b0, c_sum});
    end

    if (F >= S)
    begin : g_lvl_shr
        assign x_trunc = x_reg[F-1 -: S];
        assign y_trunc = y_reg[F-1 -: S];
    end
    else
    begin : g_lvl_shl
        assign x_trunc = {x_reg, {(S - F){1'b0}}};
        assign y_trunc = {y_reg, {(S - F){1'b0}}};
    end

    always_comb
    begin
        mul_req.start = (state_reg == ST_ISSUE);
        unique case (op_reg)
            OP_DEPTH:
            begin
                mul_req.kind = MUL_KNOB;
                mul_a        = W'(MODK_Q);
                mul_b        = W'(depth_reg);
            end
            OP_MOD:
            begin
                mul_req.kind = MUL_MAG;
                mul_a        = W'(m_reg);
                mul_b        = W'(mag_reg);
            end
            OP_RATE:
            begin
                mul_req.kind = MUL_KNOB;
                mul_a        = W'(CRANGE_Q);
                mul_b        = W'(rate_reg);
            end
            OP_OFFSET:
            begin
                mul_req.kind = MUL_KNOB;
                mul_a        = W'(OFFR_Q);
                mul_b        = W'(offs_reg);
            end
            OP_XPOLY:
            begin
                mul_req.kind = MUL_MAP;
                mul_a        = ONE - W'(x_reg);
                mul_b        = W'(x_reg);
            end
            OP_XSTEP:
            begin
                mul_req.kind = MUL_MAP;
                mul_a        = W'(c_reg);
                mul_b        = W'(p_reg);
            end
            OP_YPOLY:
            begin
                mul_req.kind = MUL_MAP;
                mul_a        = ONE - W'(y_reg);
                mul_b        = W'(y_reg);
            end
            OP_YSTEP:
            begin
                mul_req.kind = MUL_MAP;
                mul_a        = W'(c_reg) + W'(off_reg);
                mul_b        = W'(p_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        rate_next      = rate_reg;
        offs_next      = offs_reg;
        depth_next     = depth_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        m_next         = m_reg;
        r_next         = r_reg;
        off_next       = off_reg;
        c_next         = c_reg;
        p_next         = p_reg;
        x_level_next   = x_level_reg;
        y_level_next   = y_level_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RATE_KNOB:   rate_next  = cfg_data;
                REG_OFFSET_KNOB: offs_next  = cfg_data;
                REG_MOD_DEPTH:   depth_next = cfg_data;
                default:         ;
            endcase
        end

        if (map_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (mod_ch.valid)
                begin
                    state_next = ST_ISSUE;
                    op_next    = OP_DEPTH;
                    neg_next   = in_neg;
                    mag_next   = in_mag;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    unique case (op_reg)
                        OP_DEPTH, OP_MOD: m_next = res_f;
                        OP_RATE:          r_next = res_f;
                        OP_OFFSET:
                        begin
                            off_next = res_f;
                            c_next   = c_calc;
                        end
                        OP_XPOLY, OP_YPOLY: p_next = res_f;
                        OP_XSTEP:           x_next = res_f;
                        OP_YSTEP:           y_next = res_f;
                    endcase
                    if (op_reg == OP_YSTEP)
                        state_next = ST_FIN;
                    else
                    begin
                        op_next    = op_reg + 3'd1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || map_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    x_level_next   = {~x_trunc[S-1], x_trunc[S-2:0]};
                    y_level_next   = {~y_trunc[S-1], y_trunc[S-2:0]};
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_DEPTH;
            rate_reg      <= KNOB_BITS'(32768);
            offs_reg      <= '0;
            depth_reg     <= '0;
            x_reg         <= INIT_Q;
            y_reg         <= INIT_Q;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            rate_reg      <= rate_next;
            offs_reg      <= offs_next;
            depth_reg     <= depth_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        m_reg       <= m_next;
        r_reg       <= r_next;
        off_reg     <= off_next;
        c_reg       <= c_next;
        p_reg       <= p_next;
        x_level_reg <= x_level_next;
        y_level_reg <= y_level_next;
    end

    assign mod_ch.ready   = (state_reg == ST_IDLE);
    assign map_ch.valid   = out_valid_reg;
    assign map_ch.x_level = x_level_reg;
    assign map_ch.y_level = y_level_reg;

endmodule

`default_nettype wire

// ===== src/lmo_checker.sv =====
`default_nettype none
`include "logistic_map_oscillator_assert.svh"

module lmo_checker import lmo_pkg::*; #(
    parameter int S = SAMPLE_BITS_DEF
) (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         in_valid,
    input wire logic         in_ready,
    input wire logic         out_valid,
    input wire logic         out_ready,
    input wire logic [S-1:0] x_level,
    input wire logic [S-1:0] y_level
);

    // a stalled beat keeps its valid and its payload
    `LMO_ASSERT_NXT(a_out_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid)
    `LMO_ASSERT_NXT(a_out_data_holds, clk, rst_n, out_valid && !out_ready,
                    $stable(x_level) && $stable(y_level))

    // one sample in flight at a time
    `LMO_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // a new result appears only as the block frees its input side
    `LMO_ASSERT_IMP(a_result_frees_input, clk, rst_n, $rose(out_valid), in_ready)

endmodule

bind logistic_map_oscillator lmo_checker #(
    .S (SAMPLE_BITS)
) u_lmo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mod_ch.valid),
    .in_ready  (mod_ch.ready),
    .out_valid (map_ch.valid),
    .out_ready (map_ch.ready),
    .x_level   (map_ch.x_level),
    .y_level   (map_ch.y_level)
);

`default_nettype wire
